/* hw/rtl/matrix4x4_multiply_defines.svh */
// Assertion macros for the 4x4 matrix multiplier.
`ifndef MATRIX4X4_MULTIPLY_DEFINES_SVH
`define MATRIX4X4_MULTIPLY_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define M4M_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define M4M_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define M4M_ASSERT(lbl, ante, cons, msg)
`define M4M_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/m4m_pkg.sv */
// Types and constants shared by the 4x4 matrix multiplier.
`timescale 1ns / 1ps
package m4m_pkg;
  localparam int DATA_W        = 32;
  localparam int DIM           = 4;
  localparam int DEPTH         = DIM * DIM;
  localparam int IDX_W         = 2;
  localparam int ADDR_W        = 2 * IDX_W;
  localparam int SEQ_W         = 3 * IDX_W;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    FUNC_LOAD_L = 2'd0,
    FUNC_LOAD_R = 2'd1,
    FUNC_MULT   = 2'd2
  } m4m_func_e;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] k;
    logic             last;
  } m4m_tag_t;

  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  c;
    logic [IDX_W-1:0]  r;
    logic [DATA_W-1:0] value;
    logic              last;
  } m4m_res_t;
endpackage

/* hw/rtl/m4m_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module m4m_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* hw/rtl/m4m_mac.sv */
// Multiply-accumulate datapath: product, floor shift, four-term sum, saturation.
`timescale 1ns / 1ps
module m4m_mac #(
  parameter int FRAC_BITS = m4m_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  m4m_pkg::m4m_tag_t                 tag_i,
  input  logic signed [m4m_pkg::DATA_W-1:0] l_i,
  input  logic signed [m4m_pkg::DATA_W-1:0] r_i,
  output m4m_pkg::m4m_res_t                 res_o
);
  import m4m_pkg::*;

  localparam logic signed [PROD_W-1:0] SatMax = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] SatMin = -PROD_W'(64'sd2147483648);

  logic signed [PROD_W-1:0] prod_q;
  m4m_tag_t                 tag_q;
  logic signed [PROD_W-1:0] acc_q, acc_d;
  logic signed [PROD_W-1:0] term;
  logic signed [PROD_W-1:0] sum;
  logic [DATA_W-1:0]        sat;
  m4m_res_t                 res_q, res_d;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(l_i) * PROD_W'(r_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_comb begin
    term = prod_q >>> FRAC_BITS;
    sum  = ((tag_q.k == '0) ? '0 : acc_q) + term;
    if (sum > SatMax) begin
      sat = SatMax[DATA_W-1:0];
    end else if (sum < SatMin) begin
      sat = SatMin[DATA_W-1:0];
    end else begin
      sat = sum[DATA_W-1:0];
    end
    acc_d       = tag_q.valid ? sum : acc_q;
    res_d.valid = tag_q.valid && (tag_q.k == IDX_W'(DIM - 1));
    res_d.c     = tag_q.c;
    res_d.r     = tag_q.r;
    res_d.value = sat;
    res_d.last  = tag_q.last;
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;
endmodule

/* hw/rtl/matrix4x4_multiply.sv */
// Top level of the 4x4 matrix multiplier: command decode, sequencer, matrix RAMs.
//
// Channel   Direction  Handshake                 Payload
// command   in         start_i & !busy_o         func_i col_i row_i value_i
// result    out        out_strobe_o, one cycle   out_col_o out_row_o out_value_o last_o
//
// A multiply keeps busy_o high from acceptance until the last result: one RAM
// read pair per cycle over 64 (column, row, k) steps, set by the single read
// port of each matrix RAM, then the RAM read, product and result registers;
// one result leaves after each four k steps. Reset is asynchronous; matrix
// contents are undefined until loaded. Results cannot be stalled.
`timescale 1ns / 1ps
`include "matrix4x4_multiply_defines.svh"
module matrix4x4_multiply #(
  parameter int FRAC_BITS = m4m_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        func_i,
  input  logic [m4m_pkg::IDX_W-1:0]         col_i,
  input  logic [m4m_pkg::IDX_W-1:0]         row_i,
  input  logic signed [m4m_pkg::DATA_W-1:0] value_i,
  output logic                              out_strobe_o,
  output logic [m4m_pkg::IDX_W-1:0]         out_col_o,
  output logic [m4m_pkg::IDX_W-1:0]         out_row_o,
  output logic signed [m4m_pkg::DATA_W-1:0] out_value_o,
  output logic                              last_o
);
  import m4m_pkg::*;

  logic              accept;
  logic              mult_go;
  logic              we_l, we_r;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr_l, raddr_r;
  logic [DATA_W-1:0] rdata_l, rdata_r;
  logic              busy_q, busy_d;
  logic              run_q, run_d;
  logic [SEQ_W-1:0]  cnt_q, cnt_d;
  m4m_tag_t          tag_q, tag_d;
  m4m_res_t          res;

  assign accept  = start_i && !busy_q;
  assign mult_go = accept && (func_i == FUNC_MULT);
  assign we_l    = accept && (func_i == FUNC_LOAD_L);
  assign we_r    = accept && (func_i == FUNC_LOAD_R);
  assign waddr   = {col_i, row_i};

  // cnt = {c, r, k}; left is addressed {k, r}, right {c, k}
  assign raddr_l = {cnt_q[IDX_W-1:0], cnt_q[2*IDX_W-1:IDX_W]};
  assign raddr_r = {cnt_q[SEQ_W-1:2*IDX_W], cnt_q[IDX_W-1:0]};

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (mult_go) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (run_q) begin
      cnt_d = cnt_q + SEQ_W'(1);
      if (cnt_q == '1) begin
        run_d = 1'b0;
      end
    end
    if (res.valid && res.last) begin
      busy_d = 1'b0;
    end
    tag_d.valid = run_q;
    tag_d.c     = cnt_q[SEQ_W-1:2*IDX_W];
    tag_d.r     = cnt_q[2*IDX_W-1:IDX_W];
    tag_d.k     = cnt_q[IDX_W-1:0];
    tag_d.last  = (cnt_q == '1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      run_q  <= 1'b0;
      cnt_q  <= '0;
      tag_q  <= '0;
    end else begin
      busy_q <= busy_d;
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      tag_q  <= tag_d;
    end
  end

  m4m_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram_l (
    .clk_i  (clk_i),
    .we_i   (we_l),
    .waddr_i(waddr),
    .wdata_i(value_i),
    .raddr_i(raddr_l),
    .rdata_o(rdata_l)
  );

  m4m_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram_r (
    .clk_i  (clk_i),
    .we_i   (we_r),
    .waddr_i(waddr),
    .wdata_i(value_i),
    .raddr_i(raddr_r),
    .rdata_o(rdata_r)
  );

  m4m_mac #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tag_i (tag_q),
    .l_i   (rdata_l),
    .r_i   (rdata_r),
    .res_o (res)
  );

  assign busy_o       = busy_q;
  assign out_strobe_o = res.valid;
  assign out_col_o    = res.c;
  assign out_row_o    = res.r;
  assign out_value_o  = res.value;
  assign last_o       = res.valid && res.last;

  `M4M_ASSERT(a_strobe_busy, out_strobe_o, busy_o, "result beat while not busy")
  `M4M_ASSERT(a_run_busy, run_q || tag_q.valid, busy_q, "sequencer active while idle")
  `M4M_ASSERT_NEXT(a_go_busy, mult_go, busy_o && run_q, "multiply did not start")
  `M4M_ASSERT_NEXT(a_last_idle, out_strobe_o && last_o, !busy_o, "busy after last beat")
  `M4M_ASSERT(a_no_write_run, we_l || we_r, !run_q, "load during multiply")
endmodule
